@@ rtl/eased_counter_ramp_defines.svh @@
// Assertion macros for the eased counter ramp.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef EASED_COUNTER_RAMP_DEFINES_SVH
`define EASED_COUNTER_RAMP_DEFINES_SVH
`ifndef SYNTH
`define ECR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ecr check failed");
`define ECR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ecr check failed");
`else
`define ECR_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ECR_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/ecr_pkg.sv @@
// Shared types and constants for the eased counter ramp.
// No dependencies.
`timescale 1ns / 1ps
package ecr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int AMOUNT_BITS    = 32;
    localparam int SHOWN_BITS     = 32;
    localparam int STRIDE_DIV     = 25;
    localparam int GEAR_STEPS     = 24;

    typedef enum logic [1:0] {
        REQ_SET  = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_SUB  = 2'd2,
        REQ_TICK = 2'd3
    } ecr_req_t;

    typedef struct packed {
        ecr_req_t                 req_type;
        logic [AMOUNT_BITS-1:0]   amount;
        logic                     immediate;
    } ecr_in_t;

    typedef struct packed {
        logic [SHOWN_BITS-1:0]    shown_value;
        logic                     rolling;
    } ecr_out_t;

endpackage

@@ rtl/ecr_in_stage.sv @@
// Input register of the eased counter ramp: holds one request word.
// Depends on ecr_pkg.
`timescale 1ns / 1ps
module ecr_in_stage
    import ecr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  ecr_in_t s_data,
    output logic    buf_valid,
    output ecr_in_t buf_data,
    input  logic    buf_take
);

    logic    valid_reg;
    logic    valid_next;
    ecr_in_t data_reg;

    assign s_ready    = !valid_reg || buf_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign buf_valid = valid_reg;
    assign buf_data  = data_reg;

endmodule

@@ rtl/ecr_core.sv @@
// Counter state, target and stride update, and result register.
// Depends on ecr_pkg and eased_counter_ramp_defines.svh.
`timescale 1ns / 1ps
`include "eased_counter_ramp_defines.svh"
module ecr_core
    import ecr_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  ecr_in_t  in_data,
    output logic     in_take,
    output logic     out_valid,
    input  logic     out_ready,
    output ecr_out_t out_data
);

    localparam int W  = VALUE_BITS;
    localparam int EW = (W > AMOUNT_BITS) ? W : AMOUNT_BITS;
    localparam logic [W-1:0]  VMAX   = {W{1'b1}};
    localparam logic [EW-1:0] VMAX_E = EW'(VMAX);

    // divide by 25 as x * ceil(2^(W+5) / 25) >> (W+5), exact for every W-bit x
    localparam logic [W+5:0] RECIP_POW  = {1'b1, {(W+5){1'b0}}};
    localparam logic [W+5:0] RECIP_FULL = RECIP_POW / (W+6)'(STRIDE_DIV) + (W+6)'(1);
    localparam logic [W:0]   RECIP      = RECIP_FULL[W:0];

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    logic [W-1:0] shown_reg, shown_next;
    logic [W-1:0] goal_reg, goal_next;
    logic [W-1:0] stride_reg, stride_next;
    logic [W-1:0] gear_reg, gear_next;
    dir_t         dir_reg, dir_next;
    logic         out_valid_reg, out_valid_next;
    ecr_out_t     out_reg, out_next;

    logic [EW-1:0] amt_e, shown_e;
    logic [EW:0]   sum_e;
    logic [W-1:0]  goal_cmd;
    logic          apply;
    logic          up_c, dn_c;
    logic [W-1:0]  diff_c, quo_c, st_c, st24_c, first_c;
    logic [2*W:0]  prod_c;
    logic          half_t;
    logic [W-1:0]  s2_t, tick_c;
    logic          ok_t;

    assign in_take = in_valid && (!out_valid_reg || out_ready);

    always_comb begin
        amt_e   = EW'(in_data.amount);
        shown_e = EW'(shown_reg);
        sum_e   = {1'b0, shown_e} + {1'b0, amt_e};
        goal_cmd = shown_reg;
        apply    = 1'b0;
        unique case (in_data.req_type)
            REQ_SET: begin
                goal_cmd = (amt_e > VMAX_E) ? VMAX : W'(amt_e);
                apply    = (goal_cmd != shown_reg);
            end
            REQ_ADD: begin
                goal_cmd = (sum_e > {1'b0, VMAX_E}) ? VMAX : W'(sum_e);
                apply    = 1'b1;
            end
            REQ_SUB: begin
                goal_cmd = (amt_e > shown_e) ? '0 : W'(shown_e - amt_e);
                apply    = 1'b1;
            end
            REQ_TICK: begin
                goal_cmd = goal_reg;
                apply    = 1'b0;
            end
            default: begin
                goal_cmd = goal_reg;
                apply    = 1'b0;
            end
        endcase

        // start of a ramp: stride, gear point and first step
        up_c    = goal_cmd > shown_reg;
        dn_c    = goal_cmd < shown_reg;
        diff_c  = up_c ? (goal_cmd - shown_reg) : (shown_reg - goal_cmd);
        prod_c  = (2*W+1)'(diff_c) * (2*W+1)'(RECIP);
        quo_c   = {4'd0, prod_c[2*W:W+5]};
        st_c    = (quo_c == '0) ? W'(1) : quo_c;
        st24_c  = W'(st_c * W'(GEAR_STEPS));
        if (st_c < diff_c) begin
            first_c = up_c ? (shown_reg + st_c) : (shown_reg - st_c);
        end else begin
            first_c = goal_cmd;
        end

        // one tick step
        half_t = (dir_reg == DIR_UP) ? !(shown_reg < gear_reg) : !(shown_reg > gear_reg);
        if (half_t) begin
            s2_t = ((stride_reg >> 1) == '0) ? W'(1) : (stride_reg >> 1);
        end else begin
            s2_t = stride_reg;
        end
        if (dir_reg == DIR_UP) begin
            ok_t   = (goal_reg > shown_reg) && (s2_t < goal_reg - shown_reg);
            tick_c = ok_t ? (shown_reg + s2_t) : goal_reg;
        end else begin
            ok_t   = (shown_reg > goal_reg) && (s2_t < shown_reg - goal_reg);
            tick_c = ok_t ? (shown_reg - s2_t) : goal_reg;
        end

        shown_next  = shown_reg;
        goal_next   = goal_reg;
        stride_next = stride_reg;
        gear_next   = gear_reg;
        dir_next    = dir_reg;
        if (in_data.req_type != REQ_TICK) begin
            if (apply) begin
                goal_next = goal_cmd;
                if (in_data.immediate) begin
                    shown_next = goal_cmd;
                    dir_next   = DIR_IDLE;
                end else begin
                    stride_next = st_c;
                    if (up_c) begin
                        gear_next  = shown_reg + st24_c;
                        shown_next = first_c;
                        dir_next   = (first_c == goal_cmd) ? DIR_IDLE : DIR_UP;
                    end else if (dn_c) begin
                        gear_next  = shown_reg - st24_c;
                        shown_next = first_c;
                        dir_next   = (first_c == goal_cmd) ? DIR_IDLE : DIR_DOWN;
                    end else begin
                        dir_next   = DIR_IDLE;
                    end
                end
            end
        end else if (dir_reg != DIR_IDLE) begin
            if (shown_reg == goal_reg) begin
                dir_next = DIR_IDLE;
            end else begin
                stride_next = s2_t;
                shown_next  = tick_c;
                dir_next    = (tick_c == goal_reg) ? DIR_IDLE : dir_reg;
            end
        end

        out_next.shown_value = SHOWN_BITS'(shown_next);
        out_next.rolling     = (dir_next != DIR_IDLE);
        out_valid_next       = in_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg     <= '0;
            goal_reg      <= '0;
            stride_reg    <= '0;
            gear_reg      <= '0;
            dir_reg       <= DIR_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_take) begin
                shown_reg  <= shown_next;
                goal_reg   <= goal_next;
                stride_reg <= stride_next;
                gear_reg   <= gear_next;
                dir_reg    <= dir_next;
            end
        end
        if (in_take) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ECR_ASSERT_IMP(a_idle_at_goal, aclk, aresetn, dir_reg == DIR_IDLE, shown_reg == goal_reg)
    `ECR_ASSERT_IMP(a_up_below_goal, aclk, aresetn, dir_reg == DIR_UP, shown_reg < goal_reg)
    `ECR_ASSERT_IMP(a_down_above_goal, aclk, aresetn, dir_reg == DIR_DOWN, shown_reg > goal_reg)
    `ECR_ASSERT_IMP(a_stride_nonzero, aclk, aresetn, dir_reg != DIR_IDLE, stride_reg != '0)
    `ECR_ASSERT_IMP(a_rolling_matches, aclk, aresetn, out_valid_reg,
                    out_reg.rolling == (dir_reg != DIR_IDLE))

endmodule

@@ rtl/eased_counter_ramp.sv @@
// Eased counter ramp: animated display counter easing toward a target value.
// Instantiates ecr_in_stage and ecr_core; depends on ecr_pkg.
//
// Usage:
//   s_ channel carries request words (set, add, subtract or tick, with amount
//   and immediate flag); m_ channel returns one result word per request: the
//   shown value after the request and a rolling flag.
//   A request is registered in the input stage, then processed combinationally
//   against the counter state and written to the result register when m_valid
//   is low or m_ready is high; m_valid then marks the new result word.
//   Throughput: one word per cycle with m_ready high; the counter state update
//   (divide by 25 as a reciprocal multiply, gear point, one step) is
//   combinational logic.
//   Stall: while m_ready is low the result register holds; the input stage
//   still takes one more word, then s_ready drops until a result is taken.
//   Reset (aresetn low, synchronous): shown value, target, stride and gear
//   point clear to zero, the counter is idle, both channels empty.
`timescale 1ns / 1ps
module eased_counter_ramp
    import ecr_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ecr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ecr_out_t m_data
);

    logic    buf_valid;
    ecr_in_t buf_data;
    logic    buf_take;

    ecr_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .buf_valid (buf_valid),
        .buf_data  (buf_data),
        .buf_take  (buf_take)
    );

    ecr_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (buf_valid),
        .in_data   (buf_data),
        .in_take   (buf_take),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

@@ dv/tb_eased_counter_ramp.sv @@
// Self-checking testbench for eased_counter_ramp: directed table, then random command/tick runs.
// Words are checked against table values or an in-bench model; depends on ecr_pkg and the RTL.
`timescale 1ns / 1ps
module tb_eased_counter_ramp;
    import ecr_pkg::*;

    typedef enum logic [1:0] {
        RAMP_IDLE = 2'd0,
        RAMP_UP   = 2'd1,
        RAMP_DOWN = 2'd2
    } ramp_dir_t;

    typedef struct packed {
        ecr_in_t  word;
        logic     typed;
        ecr_out_t want;
    } script_row_t;

    localparam logic [63:0] VALUE_MAX   = 64'hFFFF_FFFF;
    localparam int          PHASE_WORDS = 280;
    localparam int          LONG_STALL  = 60;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ecr_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ecr_out_t m_data;

    eased_counter_ramp dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    logic [63:0] cnt_shown  = '0;
    logic [63:0] cnt_goal   = '0;
    logic [63:0] cnt_stride = '0;
    logic [63:0] cnt_gear   = '0;
    ramp_dir_t   cnt_dir    = RAMP_IDLE;

    ecr_out_t pending_display[$];
    int       errors         = 0;
    int       sent_words     = 0;
    int       send_gap_pct   = 18;
    int       recv_stall_pct = 63;
    logic     stall_req      = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("eased_counter_ramp: mismatch");
        $finish;
    end

    function automatic void ease_step();
        if (cnt_dir == RAMP_UP) begin
            if (!(cnt_shown < cnt_gear)) begin
                cnt_stride = cnt_stride >> 1;
                if (cnt_stride == 0) cnt_stride = 1;
            end
            if (cnt_goal > cnt_shown && cnt_stride < cnt_goal - cnt_shown)
                cnt_shown = cnt_shown + cnt_stride;
            else
                cnt_shown = cnt_goal;
        end else if (cnt_dir == RAMP_DOWN) begin
            if (!(cnt_shown > cnt_gear)) begin
                cnt_stride = cnt_stride >> 1;
                if (cnt_stride == 0) cnt_stride = 1;
            end
            if (cnt_shown > cnt_goal && cnt_stride < cnt_shown - cnt_goal)
                cnt_shown = cnt_shown - cnt_stride;
            else
                cnt_shown = cnt_goal;
        end
        if (cnt_shown == cnt_goal) cnt_dir = RAMP_IDLE;
    endfunction

    function automatic void head_for_goal(input logic jump);
        logic [63:0] span;
        if (jump) begin
            cnt_shown = cnt_goal;
            cnt_dir   = RAMP_IDLE;
            return;
        end
        span = (cnt_goal > cnt_shown) ? cnt_goal - cnt_shown : cnt_shown - cnt_goal;
        cnt_stride = span / STRIDE_DIV;
        if (cnt_stride == 0) cnt_stride = 1;
        if (cnt_goal > cnt_shown) begin
            cnt_gear = cnt_shown + cnt_stride * GEAR_STEPS;
            cnt_dir  = RAMP_UP;
            ease_step();
        end else if (cnt_goal < cnt_shown) begin
            cnt_gear = cnt_shown - cnt_stride * GEAR_STEPS;
            cnt_dir  = RAMP_DOWN;
            ease_step();
        end else begin
            cnt_dir = RAMP_IDLE;
        end
    endfunction

    function automatic ecr_out_t ramp_next(input ecr_in_t w);
        logic [63:0] amt;
        logic [63:0] tgt;
        ecr_out_t    r;
        amt = {32'd0, w.amount};
        case (w.req_type)
            REQ_SET: begin
                tgt = (amt > VALUE_MAX) ? VALUE_MAX : amt;
                if (tgt != cnt_shown) begin
                    cnt_goal = tgt;
                    head_for_goal(w.immediate);
                end
            end
            REQ_ADD: begin
                cnt_goal = (amt > VALUE_MAX - cnt_shown) ? VALUE_MAX : cnt_shown + amt;
                head_for_goal(w.immediate);
            end
            REQ_SUB: begin
                cnt_goal = (amt > cnt_shown) ? 64'd0 : cnt_shown - amt;
                head_for_goal(w.immediate);
            end
            default: begin
                if (cnt_dir != RAMP_IDLE) begin
                    if (cnt_shown == cnt_goal) cnt_dir = RAMP_IDLE;
                    else ease_step();
                end
            end
        endcase
        r.shown_value = cnt_shown[31:0];
        r.rolling     = (cnt_dir != RAMP_IDLE);
        return r;
    endfunction

    task automatic send_word(input ecr_in_t w, input logic typed, input ecr_out_t want);
        ecr_out_t got;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        got = ramp_next(w);
        pending_display.push_back(typed ? want : got);
        sent_words++;
    endtask

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(4))
            0:       return $urandom_range(30);
            1:       return $urandom_range(5000);
            2:       return $urandom();
            3:       return cnt_shown[31:0];
            default: return $urandom_range(2000000);
        endcase
    endfunction

    // mostly one command followed by a run of ticks, sometimes a single random word
    task automatic random_burst();
        ecr_in_t w;
        int      ticks;
        if ($urandom_range(99) < 80) begin
            w.req_type  = ecr_req_t'($urandom_range(int'(REQ_SUB)));
            w.amount    = pick_amount();
            w.immediate = ($urandom_range(7) == 0);
            send_word(w, 1'b0, '0);
            ticks = $urandom_range(36);
            repeat (ticks) begin
                w.req_type  = REQ_TICK;
                w.amount    = $urandom();
                w.immediate = 1'($urandom_range(1));
                send_word(w, 1'b0, '0);
            end
        end else begin
            w.req_type  = ecr_req_t'($urandom_range(int'(REQ_TICK)));
            w.amount    = $urandom();
            w.immediate = 1'($urandom_range(1));
            send_word(w, 1'b0, '0);
        end
    endtask

    function automatic script_row_t mk(input ecr_req_t k, input logic [31:0] a,
                                       input logic imm, input logic typed,
                                       input logic [31:0] v, input logic roll);
        script_row_t r;
        r.word.req_type    = k;
        r.word.amount      = a;
        r.word.immediate   = imm;
        r.typed            = typed;
        r.want.shown_value = v;
        r.want.rolling     = roll;
        return r;
    endfunction

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = LONG_STALL;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        ecr_out_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_display.size() == 0) begin
                $display("%0t: unexpected word, got shown_value %h rolling %b",
                         $time, m_data.shown_value, m_data.rolling);
                errors++;
            end else begin
                exp_w = pending_display.pop_front();
                if (m_data.shown_value !== exp_w.shown_value) begin
                    $display("%0t: shown_value expected %h got %h",
                             $time, exp_w.shown_value, m_data.shown_value);
                    errors++;
                end
                if (m_data.rolling !== exp_w.rolling) begin
                    $display("%0t: rolling expected %b got %b",
                             $time, exp_w.rolling, m_data.rolling);
                    errors++;
                end
            end
        end
    end

    initial begin
        script_row_t directed_rows[$];
        int          stop_at;

        // after reset, immediate on tick, set to shown value
        directed_rows.push_back(mk(REQ_TICK, 32'd0,         1'b0, 1'b1, 32'd0,         1'b0));
        directed_rows.push_back(mk(REQ_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0,         1'b0));
        directed_rows.push_back(mk(REQ_SET,  32'd0,         1'b0, 1'b1, 32'd0,         1'b0));
        // extremes: jump to max, saturating add, full subtract, floored subtract
        directed_rows.push_back(mk(REQ_SET,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(mk(REQ_ADD,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(mk(REQ_SUB,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0,         1'b0));
        directed_rows.push_back(mk(REQ_SUB,  32'd5,         1'b0, 1'b1, 32'd0,         1'b0));
        // goal reached by the first step, then a ramp toward 100 over ticks
        directed_rows.push_back(mk(REQ_SET,  32'd1,         1'b0, 1'b1, 32'd1,         1'b0));
        directed_rows.push_back(mk(REQ_SET,  32'd100,       1'b0, 1'b0, '0, 1'b0));
        repeat (5) directed_rows.push_back(mk(REQ_TICK, 32'd0, 1'b0, 1'b0, '0, 1'b0));
        // retarget while moving, then set to the current value mid-animation
        directed_rows.push_back(mk(REQ_SET,  32'd50,        1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_SET,  32'd20,        1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_TICK, 32'd7,         1'b1, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_ADD,  32'd10,        1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_SUB,  32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0));
        repeat (2) directed_rows.push_back(mk(REQ_TICK, 32'd0, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_ADD,  32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_TICK, 32'hA5A5_5A5A, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(mk(REQ_SET,  32'd0,         1'b1, 1'b1, 32'd0,         1'b0));
        directed_rows.push_back(mk(REQ_SET,  32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_gap_pct = 18; recv_stall_pct = 63; end
                1: begin send_gap_pct = 63; recv_stall_pct = 18; end
                default: begin send_gap_pct = 0; recv_stall_pct = 0; end
            endcase
            stop_at = sent_words + PHASE_WORDS / 2;
            while (sent_words < stop_at) random_burst();
            stall_req = 1'b1;
            stop_at = sent_words + PHASE_WORDS / 2;
            while (sent_words < stop_at) random_burst();
            s_valid <= 1'b0;
            wait (pending_display.size() == 0);
            @(posedge aclk);
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && pending_display.size() == 0)
            $display("eased_counter_ramp: match");
        else
            $display("eased_counter_ramp: mismatch");
        $finish;
    end

endmodule
